>>> hdl/qau_pkg.sv
// Shared types and constants of the quaternion arithmetic unit.
// Holds the opcode enum, default widths and the Hamilton product operand tables.
// No dependencies.
package qau_pkg;

  localparam int DEF_COMPONENT_WIDTH = 16;
  localparam int DEF_FRACTION_BITS   = 14;
  localparam int NUM_LANES           = 4;
  localparam int NUM_TERMS           = 4;

  typedef enum logic [2:0] {
    OP_MUL_AB = 3'd0,
    OP_MUL_BA = 3'd1,
    OP_NORM   = 3'd2,
    OP_CONJ   = 3'd3,
    OP_NEG    = 3'd4
  } op_t;

  // Component indexes; w is the scalar part.
  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  // Operand selects, indexed [order][lane][term]; order 0 is a*b, order 1 is b*a.
  localparam logic [1:0] MUL_A_SEL [2][NUM_LANES][NUM_TERMS] = '{
    '{ '{IDX_W, IDX_X, IDX_Y, IDX_Z}, '{IDX_W, IDX_Y, IDX_Z, IDX_X},
       '{IDX_W, IDX_Z, IDX_X, IDX_Y}, '{IDX_W, IDX_X, IDX_Y, IDX_Z} },
    '{ '{IDX_W, IDX_X, IDX_Z, IDX_Y}, '{IDX_W, IDX_Y, IDX_X, IDX_Z},
       '{IDX_W, IDX_Z, IDX_Y, IDX_X}, '{IDX_W, IDX_X, IDX_Y, IDX_Z} }
  };

  localparam logic [1:0] MUL_B_SEL [2][NUM_LANES][NUM_TERMS] = '{
    '{ '{IDX_X, IDX_W, IDX_Z, IDX_Y}, '{IDX_Y, IDX_W, IDX_X, IDX_Z},
       '{IDX_Z, IDX_W, IDX_Y, IDX_X}, '{IDX_W, IDX_X, IDX_Y, IDX_Z} },
    '{ '{IDX_X, IDX_W, IDX_Y, IDX_Z}, '{IDX_Y, IDX_W, IDX_Z, IDX_X},
       '{IDX_Z, IDX_W, IDX_X, IDX_Y}, '{IDX_W, IDX_X, IDX_Y, IDX_Z} }
  };

  // Bit k set means term k is subtracted.
  localparam logic [NUM_TERMS-1:0] MUL_NEG [NUM_LANES] = '{
    4'b1000, 4'b1000, 4'b1000, 4'b1110
  };

endpackage

>>> hdl/qau_lane.sv
// One product lane: four signed multiplies, their signed sum, and the square
// of one component of a. Two register stages. Depends on qau_pkg.
module qau_lane #(
  parameter int COMPONENT_WIDTH = qau_pkg::DEF_COMPONENT_WIDTH
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [COMPONENT_WIDTH-1:0]   u [qau_pkg::NUM_TERMS],
  input  logic signed [COMPONENT_WIDTH-1:0]   v [qau_pkg::NUM_TERMS],
  input  logic [qau_pkg::NUM_TERMS-1:0]       neg,
  input  logic signed [COMPONENT_WIDTH-1:0]   sq_in,
  output logic signed [2*COMPONENT_WIDTH+1:0] sum,
  output logic [2*COMPONENT_WIDTH-1:0]        sq
);
  import qau_pkg::*;

  localparam int PW = 2 * COMPONENT_WIDTH;
  localparam int SW = PW + 2;

  logic signed [PW-1:0]    prod [NUM_TERMS];
  logic signed [PW-1:0]    sq_prod;
  logic [NUM_TERMS-1:0]    neg_q;
  logic signed [SW-1:0]    sum_next;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        prod[k] <= u[k] * v[k];
      end
      sq_prod <= sq_in * sq_in;
      neg_q   <= neg;
      sum     <= sum_next;
    end
  end

  always_comb begin
    sum_next = '0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      if (neg_q[k]) sum_next = sum_next - SW'(prod[k]);
      else          sum_next = sum_next + SW'(prod[k]);
    end
  end

  assign sq = $unsigned(sq_prod);

endmodule

>>> hdl/qau_sqrt.sv
// Pipelined square root with round to nearest, one result bit per stage.
// The stage registers feed a register that holds the rounded root m. Depends on qau_pkg.
module qau_sqrt #(
  parameter int COMPONENT_WIDTH = qau_pkg::DEF_COMPONENT_WIDTH
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [2*COMPONENT_WIDTH+1:0] s,
  output logic [COMPONENT_WIDTH:0]     m
);
  import qau_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int NS = CW + 1;
  localparam int SW = 2 * CW + 2;
  localparam int RW = CW + 3;

  logic [SW-1:0] rad_q  [NS];
  logic [RW-1:0] rem_q  [NS];
  logic [CW:0]   root_q [NS];
  logic [SW-1:0] rad_in  [NS];
  logic [RW-1:0] rem_in  [NS];
  logic [CW:0]   root_in [NS];
  logic [SW-1:0] rad_next  [NS];
  logic [RW-1:0] rem_next  [NS];
  logic [CW:0]   root_next [NS];
  logic [RW-1:0] rem_sh [NS];
  logic [RW-1:0] trial  [NS];
  logic          ge     [NS];

  always_comb begin
    rad_in[0]  = s;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int k = 1; k < NS; k++) begin
      rad_in[k]  = rad_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      rem_sh[k]    = {rem_in[k][RW-3:0], rad_in[k][SW-1:SW-2]};
      trial[k]     = {root_in[k], 2'b01};
      ge[k]        = (rem_sh[k] >= trial[k]);
      rem_next[k]  = ge[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
      root_next[k] = {root_in[k][CW-1:0], ge[k]};
      rad_next[k]  = {rad_in[k][SW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        rad_q[k]  <= rad_next[k];
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
      end
      // Round up when the remainder exceeds the root.
      m <= root_q[NS-1] + (CW+1)'(rem_q[NS-1] > {2'b00, root_q[NS-1]});
    end
  end

endmodule

>>> hdl/qau_div.sv
// Pipelined restoring divider for one normalize lane, one quotient bit per stage.
// The quotient is known to fit FRACTION_BITS + 1 bits. Depends on qau_pkg.
module qau_div #(
  parameter int COMPONENT_WIDTH = qau_pkg::DEF_COMPONENT_WIDTH,
  parameter int FRACTION_BITS   = qau_pkg::DEF_FRACTION_BITS
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic [COMPONENT_WIDTH+FRACTION_BITS:0]     num,
  input  logic [COMPONENT_WIDTH:0]                   den,
  output logic [FRACTION_BITS:0]                     q
);
  import qau_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int QN = FRACTION_BITS + 1;
  localparam int NW = CW + FRACTION_BITS + 1;

  logic [CW:0]   rem_q  [QN];
  logic [QN-1:0] low_q  [QN];
  logic [QN-1:0] quot_q [QN];
  logic [CW:0]   den_q  [QN];
  logic [CW:0]   rem_in  [QN];
  logic [QN-1:0] low_in  [QN];
  logic [QN-1:0] quot_in [QN];
  logic [CW:0]   den_in  [QN];
  logic [CW+1:0] rsh  [QN];
  logic [CW+1:0] diff [QN];
  logic          ge   [QN];
  logic [CW:0]   rem_next  [QN];
  logic [QN-1:0] low_next  [QN];
  logic [QN-1:0] quot_next [QN];

  always_comb begin
    rem_in[0]  = {1'b0, num[NW-1:QN]};
    low_in[0]  = num[QN-1:0];
    quot_in[0] = '0;
    den_in[0]  = den;
    for (int k = 1; k < QN; k++) begin
      rem_in[k]  = rem_q[k-1];
      low_in[k]  = low_q[k-1];
      quot_in[k] = quot_q[k-1];
      den_in[k]  = den_q[k-1];
    end
    for (int k = 0; k < QN; k++) begin
      rsh[k]       = {rem_in[k], low_in[k][QN-1]};
      diff[k]      = rsh[k] - {1'b0, den_in[k]};
      ge[k]        = (rsh[k] >= {1'b0, den_in[k]});
      rem_next[k]  = ge[k] ? diff[k][CW:0] : rsh[k][CW:0];
      low_next[k]  = {low_in[k][QN-2:0], 1'b0};
      quot_next[k] = {quot_in[k][QN-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QN; k++) begin
        rem_q[k]  <= rem_next[k];
        low_q[k]  <= low_next[k];
        quot_q[k] <= quot_next[k];
        den_q[k]  <= den_in[k];
      end
    end
  end

  assign q = quot_q[QN-1];

endmodule

>>> hdl/qau_merge.sv
// Merging stage: picks each lane's result by opcode, rounds products,
// saturates every component and the length, and raises the clip flag. Depends on qau_pkg.
module qau_merge #(
  parameter int COMPONENT_WIDTH = qau_pkg::DEF_COMPONENT_WIDTH,
  parameter int FRACTION_BITS   = qau_pkg::DEF_FRACTION_BITS
) (
  input  qau_pkg::op_t                          op,
  input  logic signed [COMPONENT_WIDTH-1:0]     a   [qau_pkg::NUM_LANES],
  input  logic signed [2*COMPONENT_WIDTH+1:0]   sum [qau_pkg::NUM_LANES],
  input  logic [FRACTION_BITS:0]                q   [qau_pkg::NUM_LANES],
  input  logic [COMPONENT_WIDTH:0]              m,
  output logic signed [COMPONENT_WIDTH-1:0]     r   [qau_pkg::NUM_LANES],
  output logic [COMPONENT_WIDTH-1:0]            mag,
  output logic                                  clip
);
  import qau_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int MW = (2 * CW + 2 > F + 3) ? 2 * CW + 2 : F + 3;
  localparam logic signed [MW-1:0] HALF = MW'(1) << (F - 1);
  localparam logic signed [MW-1:0] ONE  = MW'(1) << F;

  logic signed [MW-1:0] val [NUM_LANES];
  logic signed [MW-1:0] ae  [NUM_LANES];
  logic signed [MW-1:0] qs  [NUM_LANES];
  logic [MW-CW:0]       hi  [NUM_LANES];

  always_comb begin
    clip = m[CW];
    mag  = m[CW] ? '1 : m[CW-1:0];
    for (int i = 0; i < NUM_LANES; i++) begin
      ae[i] = MW'(a[i]);
      qs[i] = MW'(signed'({1'b0, q[i]}));
      unique case (op)
        OP_MUL_AB, OP_MUL_BA: val[i] = (MW'(sum[i]) + HALF) >>> F;
        OP_NORM: begin
          if (m == '0) val[i] = (i == int'(IDX_W)) ? ONE : '0;
          else         val[i] = a[i][CW-1] ? -qs[i] : qs[i];
        end
        OP_CONJ: val[i] = (i == int'(IDX_W)) ? ae[i] : -ae[i];
        OP_NEG:  val[i] = -ae[i];
        default: val[i] = '0;
      endcase
      // In range only when all bits above the sign agree with it.
      hi[i] = val[i][MW-1:CW-1];
      if ((hi[i] != '0) && (hi[i] != '1)) begin
        r[i] = val[i][MW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        clip = 1'b1;
      end else begin
        r[i] = val[i][CW-1:0];
      end
    end
  end

endmodule

>>> hdl/quaternion_arith_unit.sv
// Quaternion arithmetic unit: Hamilton products, normalize, conjugate, negate.
// The square root and divider pipelines set the delay from input item to output item.
// Throughput: one item per cycle; the pipeline stops as a whole only while a finished
// item waits on a stalled output, and the input is stalled in that same cycle.
// Reset (synchronous, rst high) clears the pipeline valid bits and the output valid.
module quaternion_arith_unit #(
  parameter int COMPONENT_WIDTH = qau_pkg::DEF_COMPONENT_WIDTH,
  parameter int FRACTION_BITS   = qau_pkg::DEF_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        opcode,
  input  logic signed [COMPONENT_WIDTH-1:0] a_x,
  input  logic signed [COMPONENT_WIDTH-1:0] a_y,
  input  logic signed [COMPONENT_WIDTH-1:0] a_z,
  input  logic signed [COMPONENT_WIDTH-1:0] a_w,
  input  logic signed [COMPONENT_WIDTH-1:0] b_x,
  input  logic signed [COMPONENT_WIDTH-1:0] b_y,
  input  logic signed [COMPONENT_WIDTH-1:0] b_z,
  input  logic signed [COMPONENT_WIDTH-1:0] b_w,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COMPONENT_WIDTH-1:0] r_x,
  output logic signed [COMPONENT_WIDTH-1:0] r_y,
  output logic signed [COMPONENT_WIDTH-1:0] r_z,
  output logic signed [COMPONENT_WIDTH-1:0] r_w,
  output logic [COMPONENT_WIDTH-1:0]        magnitude,
  output logic                              saturated
);
  import qau_pkg::*;

  // Pipeline map, by side chain index k (side_a[k]) after the input register (stage S1):
  //   lanes multiply in S1 and sum alongside side index 0, together with the sum of squares;
  //   the square root delivers the rounded length alongside side index NS + 1;
  //   the four divider lanes deliver quotients alongside side index LS - 1;
  //   the merging stage feeds the output register from side index LS - 1.
  localparam int CW = COMPONENT_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int SW = 2 * CW + 2;
  localparam int NS = CW + 1;
  localparam int QN = F + 1;
  localparam int NW = CW + F + 1;
  localparam int LS = NS + QN + 2;

  logic signed [CW-1:0] a_in [NUM_LANES];
  logic signed [CW-1:0] b_in [NUM_LANES];

  logic          adv;
  logic          out_take;
  logic [LS:0]   vld;

  op_t                  s1_op;
  logic signed [CW-1:0] s1_a [NUM_LANES];

  logic signed [CW-1:0] lane_u [NUM_LANES][NUM_TERMS];
  logic signed [CW-1:0] lane_v [NUM_LANES][NUM_TERMS];
  logic                 order;
  logic signed [SW-1:0] lane_sum [NUM_LANES];
  logic [2*CW-1:0]      lane_sq  [NUM_LANES];

  logic [SW-1:0]        ssum;
  op_t                  side_op [LS];
  logic signed [CW-1:0] side_a  [LS][NUM_LANES];
  logic signed [SW-1:0] sum_line [LS-1][NUM_LANES];

  logic [CW:0]          m;
  logic [CW:0]          m_line [QN];
  logic [CW-1:0]        abs_a  [NUM_LANES];
  logic [NW-1:0]        num    [NUM_LANES];
  logic [F:0]           quot   [NUM_LANES];

  logic signed [CW-1:0] mrg_r [NUM_LANES];
  logic [CW-1:0]        mrg_mag;
  logic                 mrg_clip;

  assign a_in = '{a_x, a_y, a_z, a_w};
  assign b_in = '{b_x, b_y, b_z, b_w};

  // The whole pipeline moves together. It may move whenever its last stage is
  // empty or the output register can take that stage's item.
  assign out_take = !out_valid || !out_stall;
  assign adv      = !vld[LS] || out_take;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LS-1:0], in_valid};
    end
  end

  // Input register and side chain that carries opcode, a, the sums and the length.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op      <= op_t'(opcode);
      s1_a       <= a_in;
      side_op[0] <= s1_op;
      side_a[0]  <= s1_a;
      ssum       <= {2'b00, lane_sq[0]} + {2'b00, lane_sq[1]}
                  + {2'b00, lane_sq[2]} + {2'b00, lane_sq[3]};
      for (int k = 1; k < LS; k++) begin
        side_op[k] <= side_op[k-1];
        side_a[k]  <= side_a[k-1];
      end
      sum_line[0] <= lane_sum;
      for (int k = 1; k < LS - 1; k++) begin
        sum_line[k] <= sum_line[k-1];
      end
      m_line[0] <= m;
      for (int k = 1; k < QN; k++) begin
        m_line[k] <= m_line[k-1];
      end
    end
  end

  // Operand selection for the Hamilton product: the operator order flips
  // the sign of the cross-product terms.
  assign order = (op_t'(opcode) == OP_MUL_BA);

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        lane_u[i][k] = a_in[MUL_A_SEL[order][i][k]];
        lane_v[i][k] = b_in[MUL_B_SEL[order][i][k]];
      end
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    qau_lane #(
      .COMPONENT_WIDTH (CW)
    ) u_lane (
      .clk   (clk),
      .en    (adv),
      .u     (lane_u[i]),
      .v     (lane_v[i]),
      .neg   (MUL_NEG[i]),
      .sq_in (a_in[i]),
      .sum   (lane_sum[i]),
      .sq    (lane_sq[i])
    );
  end

  // Length of a, rounded to the nearest integer.
  qau_sqrt #(
    .COMPONENT_WIDTH (CW)
  ) u_sqrt (
    .clk (clk),
    .en  (adv),
    .s   (ssum),
    .m   (m)
  );

  // Normalize lanes divide |a_i| * 2^F + m/2 by m; the sign is restored at merge.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      abs_a[i] = side_a[NS+1][i][CW-1] ? (~side_a[NS+1][i] + 1'b1) : side_a[NS+1][i];
      num[i]   = NW'({abs_a[i], {F{1'b0}}}) + NW'(m[CW:1]);
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_div
    qau_div #(
      .COMPONENT_WIDTH (CW),
      .FRACTION_BITS   (F)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .num (num[i]),
      .den (m),
      .q   (quot[i])
    );
  end

  qau_merge #(
    .COMPONENT_WIDTH (CW),
    .FRACTION_BITS   (F)
  ) u_merge (
    .op   (side_op[LS-1]),
    .a    (side_a[LS-1]),
    .sum  (sum_line[LS-2]),
    .q    (quot),
    .m    (m_line[QN-1]),
    .r    (mrg_r),
    .mag  (mrg_mag),
    .clip (mrg_clip)
  );

  // Output register. It holds a finished item until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (vld[LS] && out_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[LS] && out_take) begin
      r_x       <= mrg_r[IDX_X];
      r_y       <= mrg_r[IDX_Y];
      r_z       <= mrg_r[IDX_Z];
      r_w       <= mrg_r[IDX_W];
      magnitude <= mrg_mag;
      saturated <= mrg_clip;
    end
  end

  // The pipeline only stops when a finished item waits on a stalled output.
  assert property (@(posedge clk) disable iff (rst)
    !adv |-> (vld[LS] && out_valid && out_stall))
    else $error("pipeline stopped without a blocked output");

  // A finished item held by a stop is still there in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (vld[LS] && !adv) |=> vld[LS])
    else $error("finished item lost while stopped");

  // An accepted item enters the first stage.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted item did not enter the pipeline");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for quaternion_arith_unit: directed and random items,
// with a scoreboard class that predicts every result. Depends on hdl/qau_pkg.sv
// and hdl/quaternion_arith_unit.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qau_pkg::*;

  localparam int CW = DEF_COMPONENT_WIDTH;
  localparam int FB = DEF_FRACTION_BITS;
  localparam int RANDOM_ITEMS = 680;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_LEN = 230;
  localparam int HOLD_AT = 300;
  // Codes 5 to 7 are not operations; the block must zero the components.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;
  localparam longint SMAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint UMAX = (longint'(1) <<< CW) - 1;

  typedef logic signed [CW-1:0] comp_t;

  // One input item: an opcode and two quaternions, indexed x, y, z, w.
  typedef struct {
    logic [2:0] op;
    comp_t a [4];
    comp_t b [4];
  } quat_item_t;

  // One result item as the block reports it.
  typedef struct {
    comp_t r [4];
    logic [CW-1:0] mag;
    logic sat;
  } quat_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] opcode = '0;
  comp_t a_x = '0, a_y = '0, a_z = '0, a_w = '0;
  comp_t b_x = '0, b_y = '0, b_z = '0, b_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  comp_t r_x, r_y, r_z, r_w;
  logic [CW-1:0] magnitude;
  logic saturated;

  quaternion_arith_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
    .magnitude(magnitude), .saturated(saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Clip a wide value to the signed component range, noting any clipping.
  function automatic comp_t clip_comp(input longint v, inout bit clipped);
    if (v > SMAX) begin
      v = SMAX;
      clipped = 1'b1;
    end
    if (v < SMIN) begin
      v = SMIN;
      clipped = 1'b1;
    end
    return comp_t'(v);
  endfunction

  // A sum of products carries 2*FB fraction bits; round half up to FB bits.
  function automatic longint round_product(input longint s);
    return (s + (longint'(1) <<< (FB - 1))) >>> FB;
  endfunction

  // Square root rounded to the nearest integer.
  function automatic longint root_nearest(input longint s);
    longint r;
    longint t;
    r = 0;
    for (int k = 17; k >= 0; k--) begin
      t = r | (longint'(1) <<< k);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  // Scale one component by one over the length, rounding the magnitude half up.
  function automatic longint scale_to_unit(input longint v, input longint len);
    longint q;
    q = (((v < 0) ? -v : v) * (longint'(1) <<< FB) + (len >>> 1)) / len;
    return (v < 0) ? -q : q;
  endfunction

  // Works out the block's answer for one item.
  function automatic quat_result_t quat_expected(input quat_item_t it);
    quat_result_t res;
    longint ax, ay, az, aw, bx, by, bz, bw, len_sq, len;
    longint wide [4];
    bit clipped;
    ax = it.a[IDX_X]; ay = it.a[IDX_Y]; az = it.a[IDX_Z]; aw = it.a[IDX_W];
    bx = it.b[IDX_X]; by = it.b[IDX_Y]; bz = it.b[IDX_Z]; bw = it.b[IDX_W];
    clipped = 1'b0;
    len_sq = ax * ax + ay * ay + az * az + aw * aw;
    len = root_nearest(len_sq);
    if (len > UMAX) begin
      res.mag = UMAX[CW-1:0];
      clipped = 1'b1;
    end else begin
      res.mag = len[CW-1:0];
    end
    wide = '{0, 0, 0, 0};
    case (it.op)
      OP_MUL_AB: begin
        wide[IDX_X] = round_product(aw * bx + ax * bw + ay * bz - az * by);
        wide[IDX_Y] = round_product(aw * by + ay * bw + az * bx - ax * bz);
        wide[IDX_Z] = round_product(aw * bz + az * bw + ax * by - ay * bx);
        wide[IDX_W] = round_product(aw * bw - ax * bx - ay * by - az * bz);
      end
      OP_MUL_BA: begin
        wide[IDX_X] = round_product(aw * bx + ax * bw + az * by - ay * bz);
        wide[IDX_Y] = round_product(aw * by + ay * bw + ax * bz - az * bx);
        wide[IDX_Z] = round_product(aw * bz + az * bw + ay * bx - ax * by);
        wide[IDX_W] = round_product(aw * bw - ax * bx - ay * by - az * bz);
      end
      OP_NORM: begin
        if (len == 0) begin
          wide[IDX_W] = longint'(1) <<< FB;
        end else begin
          wide[IDX_X] = scale_to_unit(ax, len);
          wide[IDX_Y] = scale_to_unit(ay, len);
          wide[IDX_Z] = scale_to_unit(az, len);
          wide[IDX_W] = scale_to_unit(aw, len);
        end
      end
      OP_CONJ: wide = '{-ax, -ay, -az, aw};
      OP_NEG:  wide = '{-ax, -ay, -az, -aw};
      default: ;
    endcase
    for (int i = 0; i < 4; i++) res.r[i] = clip_comp(wide[i], clipped);
    res.sat = clipped;
    return res;
  endfunction

  // Holds the expected results in order and compares each arriving result.
  class quat_scoreboard;
    quat_result_t pending [$];
    int errors;
    int checked;

    task report(input string msg);
      $display("tb_top: mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void note_item(input quat_item_t it);
      pending.push_back(quat_expected(it));
    endfunction

    task check_result(input quat_result_t got);
      quat_result_t want;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      checked++;
      for (int i = 0; i < 4; i++)
        if (got.r[i] !== want.r[i])
          report($sformatf("result %0d component %0d: got %0d, expected %0d",
                           checked, i, got.r[i], want.r[i]));
      if (got.mag !== want.mag)
        report($sformatf("result %0d magnitude: got %0d, expected %0d",
                         checked, got.mag, want.mag));
      if (got.sat !== want.sat)
        report($sformatf("result %0d saturated: got %b, expected %b",
                         checked, got.sat, want.sat));
    endtask
  endclass

  quat_scoreboard sb = new();
  quat_item_t stim [$];
  int n_sent = 0;
  int n_got = 0;
  int total_items = 0;
  int quiet = 0;
  bit holding = 1'b0;
  bit held_once = 1'b0;
  int op_seen [8];

  task automatic add_item(input logic [2:0] op, input longint ax, input longint ay,
                          input longint az, input longint aw, input longint bx,
                          input longint by, input longint bz, input longint bw);
    quat_item_t it;
    it.op = op;
    it.a = '{comp_t'(ax), comp_t'(ay), comp_t'(az), comp_t'(aw)};
    it.b = '{comp_t'(bx), comp_t'(by), comp_t'(bz), comp_t'(bw)};
    stim.push_back(it);
  endtask

  // Random component: mostly anywhere in range, sometimes near unit length so
  // that products and normalized values stay in the interesting middle band,
  // and sometimes very small or pinned to an extreme.
  function automatic longint pick_comp();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? SMAX : SMIN;
      1, 2, 3: return longint'($urandom_range(0, 2 * 8192)) - 8192;
      4: return longint'($urandom_range(0, 64)) - 32;
      default: return longint'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic build_stimulus();
    longint one;
    logic [2:0] op;
    one = longint'(1) <<< FB;
    // Directed items: identities, basis products, zero length, extremes.
    add_item(OP_MUL_AB, 0, 0, 0, one, 0, 0, 0, one);
    add_item(OP_MUL_AB, one, 0, 0, 0, 0, one, 0, 0);
    add_item(OP_MUL_BA, one, 0, 0, 0, 0, one, 0, 0);
    add_item(OP_MUL_AB, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
    add_item(OP_MUL_BA, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
    add_item(OP_MUL_AB, SMIN, SMAX, SMIN, SMAX, SMAX, SMIN, SMAX, SMIN);
    add_item(OP_MUL_AB, 1, -1, 1, -1, 8192, 8192, -8192, 8192);
    add_item(OP_NORM, 0, 0, 0, 0, SMAX, SMIN, 1, -1);
    add_item(OP_NORM, one, 0, 0, 0, 0, 0, 0, 0);
    add_item(OP_NORM, 0, 0, 1, 0, 0, 0, 0, 0);
    add_item(OP_NORM, 3, -4, 0, 0, 0, 0, 0, 0);
    add_item(OP_NORM, SMIN, SMIN, SMIN, SMIN, 0, 0, 0, 0);
    add_item(OP_NORM, SMAX, -5, 7, SMIN, 0, 0, 0, 0);
    add_item(OP_CONJ, SMIN, SMIN, SMIN, SMIN, 0, 0, 0, 0);
    add_item(OP_CONJ, SMAX, 1, -1, SMAX, 0, 0, 0, 0);
    add_item(OP_NEG, SMIN, SMIN, SMIN, SMIN, 0, 0, 0, 0);
    add_item(OP_NEG, SMAX, -1, 0, 1, 0, 0, 0, 0);
    add_item(OP_NEG, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(OP_SPARE_FIRST, 100, 200, 300, 400, 1, 2, 3, 4);
    add_item(OP_SPARE_FIRST + 3'd1, SMIN, SMIN, SMIN, SMIN, SMAX, 0, 0, 0);
    add_item(OP_SPARE_LAST, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Real operations dominate; the unused codes turn up now and then.
      if ($urandom_range(0, 39) == 0) op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      else op = 3'($urandom_range(OP_MUL_AB, OP_NEG));
      add_item(op, pick_comp(), pick_comp(), pick_comp(), pick_comp(),
               pick_comp(), pick_comp(), pick_comp(), pick_comp());
    end
    total_items = stim.size();
  endtask

  // Drives the input side, collects results and watches for a hang. Everything
  // is sampled at the rising edge before the block's own updates land, and each
  // driven signal gets one nonblocking assignment per edge at most.
  always @(posedge clk) begin
    bit progress;
    bit offer;
    int send_idle;
    int recv_idle;
    quat_result_t got;
    if (!rst) begin
      progress = 1'b0;
      if (out_valid && !out_stall) begin
        got.r = '{r_x, r_y, r_z, r_w};
        got.mag = magnitude;
        got.sat = saturated;
        sb.check_result(got);
        n_got++;
        progress = 1'b1;
      end
      if (in_valid && !in_stall) begin
        op_seen[opcode]++;
        sb.note_item(stim.pop_front());
        n_sent++;
        progress = 1'b1;
      end

      // Three idling phases: sender busy-ish and receiver mostly stalled, then
      // the reverse, then full speed on both sides.
      if (n_sent < PHASE_LEN) begin
        send_idle = 23;
        recv_idle = 80;
      end else if (n_sent < 2 * PHASE_LEN) begin
        send_idle = 80;
        recv_idle = 23;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end

      // Once, the sender stops until the pipeline has drained completely.
      if (!held_once && n_sent == HOLD_AT) begin
        holding = 1'b1;
        held_once = 1'b1;
      end
      if (holding && sb.pending.size() == 0) holding = 1'b0;

      // A presented item stays put until accepted.
      if (!(in_valid && in_stall)) begin
        offer = stim.size() != 0 && !holding && $urandom_range(0, 99) >= send_idle;
        if (offer) begin
          opcode <= stim[0].op;
          {a_x, a_y, a_z, a_w} <= {stim[0].a[IDX_X], stim[0].a[IDX_Y],
                                   stim[0].a[IDX_Z], stim[0].a[IDX_W]};
          {b_x, b_y, b_z, b_w} <= {stim[0].b[IDX_X], stim[0].b[IDX_Y],
                                   stim[0].b[IDX_Z], stim[0].b[IDX_W]};
        end
        in_valid <= offer;
      end
      out_stall <= $urandom_range(0, 99) < recv_idle;

      quiet = progress ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top: no progress for %0d cycles", QUIET_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (n_sent < total_items) @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // Anything arriving now has no expectation and is flagged by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d items sent, %0d results checked, %0d mismatches",
             n_sent, n_got, sb.errors);
    $display("tb_top: ops a*b %0d, b*a %0d, norm %0d, conj %0d, neg %0d, unused %0d",
             op_seen[OP_MUL_AB], op_seen[OP_MUL_BA], op_seen[OP_NORM],
             op_seen[OP_CONJ], op_seen[OP_NEG],
             op_seen[5] + op_seen[6] + op_seen[7]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> quaternion_arith_unit.f
hdl/qau_pkg.sv
hdl/qau_lane.sv
hdl/qau_sqrt.sv
hdl/qau_div.sv
hdl/qau_merge.sv
hdl/quaternion_arith_unit.sv
sim/tb_top.sv
